// File: hdl/assert_macros.svh
// Assertion macros used by h2r_checker, the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication within the same cycle, clocked on clk_i, off while in reset.
`define H2R_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle, clocked on clk_i, off while in reset.
`define H2R_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/h2r_pkg.sv
// Types and constants of the HSL to RGB converter.
package h2r_pkg;

  localparam int unsigned FRAC_BITS = 12;            // 1.0 == 2**FRAC_BITS
  localparam int unsigned SL_W      = 13;            // saturation/lightness field
  localparam int unsigned HUE_W     = 9;             // hue field
  localparam int unsigned CH_W      = 8;             // output channel
  localparam int unsigned W_W       = 6;             // ramp weight, 0..60
  localparam int unsigned LS_W      = 2 * SL_W;      // l*s product
  localparam int unsigned Q_W       = LS_W + 2;      // signed q and p
  localparam int unsigned D_W       = Q_W + 1;       // signed q-p
  localparam int unsigned PR_W      = D_W + W_W + 1; // signed (q-p)*w
  localparam int unsigned V_W       = PR_W + 1;      // signed 60*channel
  localparam int unsigned T_W       = V_W + 5;       // signed 17*V
  // v*255/(60*ONE^2) == v*17 / 2**(2*FRAC_BITS+2)
  localparam int unsigned OUT_SHIFT = 2 * FRAC_BITS + 2;
  localparam int unsigned STAGES    = 5;

  localparam logic [SL_W-1:0]  HALF     = SL_W'(1 << (FRAC_BITS - 1));
  localparam logic [HUE_W:0]   DEG_60   = (HUE_W+1)'(60);
  localparam logic [HUE_W:0]   DEG_120  = (HUE_W+1)'(120);
  localparam logic [HUE_W:0]   DEG_180  = (HUE_W+1)'(180);
  localparam logic [HUE_W:0]   DEG_240  = (HUE_W+1)'(240);
  localparam logic [HUE_W:0]   DEG_360  = (HUE_W+1)'(360);
  localparam logic [W_W-1:0]   RAMP_MAX = W_W'(60);
  localparam logic [CH_W-1:0]  CH_MAX   = '1;

  typedef logic [W_W-1:0] weight_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue_deg;
    logic [SL_W-1:0]  saturation;
    logic [SL_W-1:0]  lightness;
  } in_beat_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } out_beat_t;

  typedef struct packed {
    weight_t red;
    weight_t green;
    weight_t blue;
  } weights_t;

  typedef struct packed {
    logic [SL_W-1:0] lightness;
    logic [SL_W-1:0] saturation;
    logic [LS_W-1:0] ls;
    logic            lo_half;   // 2*l < 1.0
    weights_t        w;
  } prep_t;

  typedef struct packed {
    logic signed [Q_W-1:0] p;
    logic signed [D_W-1:0] diff;
    weights_t              w;
  } mix_t;

endpackage

// File: hdl/h2r_prep.sv
// Stage 1: hue reduction, per-channel ramp weights and the l*s product.
module h2r_prep (
  input  logic             clk_i,
  input  logic             en_i,
  input  h2r_pkg::in_beat_t beat_i,
  output h2r_pkg::prep_t    prep_o
);
  import h2r_pkg::*;

  // a in 0..719 -> a mod 360
  function automatic logic [HUE_W-1:0] hue_wrap(input logic [HUE_W:0] a);
    logic [HUE_W:0] t;
    t = a - DEG_360;
    if (a >= DEG_360) begin
      return t[HUE_W-1:0];
    end
    return a[HUE_W-1:0];
  endfunction

  // weight of q in the channel value, out of 60
  function automatic weight_t ramp_weight(input logic [HUE_W-1:0] d);
    logic [HUE_W:0] dx;
    logic [HUE_W:0] t;
    dx = {1'b0, d};
    t  = DEG_240 - dx;
    if (dx < DEG_60) begin
      return dx[W_W-1:0];
    end else if (dx < DEG_180) begin
      return RAMP_MAX;
    end else if (dx < DEG_240) begin
      return t[W_W-1:0];
    end
    return '0;
  endfunction

  logic [HUE_W-1:0] hm;
  prep_t            prep_d;
  prep_t            prep_q;

  always_comb begin
    hm                = hue_wrap({1'b0, beat_i.hue_deg});
    prep_d.lightness  = beat_i.lightness;
    prep_d.saturation = beat_i.saturation;
    prep_d.ls         = LS_W'(beat_i.lightness) * LS_W'(beat_i.saturation);
    prep_d.lo_half    = beat_i.lightness < HALF;
    prep_d.w.green    = ramp_weight(hm);
    prep_d.w.red      = ramp_weight(hue_wrap({1'b0, hm} + DEG_120));
    prep_d.w.blue     = ramp_weight(hue_wrap({1'b0, hm} + DEG_240));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prep_q <= prep_d;
    end
  end

  assign prep_o = prep_q;

endmodule

// File: hdl/h2r_mix.sv
// Stage 2: the two intermediates, kept as p and q-p (scaled by ONE^2).
module h2r_mix (
  input  logic           clk_i,
  input  logic           en_i,
  input  h2r_pkg::prep_t prep_i,
  output h2r_pkg::mix_t  mix_o
);
  import h2r_pkg::*;

  logic signed [Q_W-1:0] q;
  logic signed [Q_W-1:0] l2;
  logic signed [Q_W-1:0] ls;
  mix_t                  mix_d;
  mix_t                  mix_q;

  always_comb begin
    ls = signed'(Q_W'(prep_i.ls));
    l2 = signed'(Q_W'(prep_i.lightness) << (FRAC_BITS + 1));
    if (prep_i.lo_half) begin
      q = signed'(Q_W'(prep_i.lightness) << FRAC_BITS) + ls;
    end else begin
      q = signed'((Q_W'(prep_i.lightness) + Q_W'(prep_i.saturation)) << FRAC_BITS) - ls;
    end
    mix_d.p    = l2 - q;
    mix_d.diff = (D_W'(q) <<< 1) - D_W'(l2);   // q - p
    mix_d.w    = prep_i.w;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mix_q <= mix_d;
    end
  end

  assign mix_o = mix_q;

endmodule

// File: hdl/h2r_chan.sv
// Stages 3 to 5 of one color channel: ramp product, sum, scale and clamp.
module h2r_chan (
  input  logic                         clk_i,
  input  logic [2:0]                   en_i,
  input  logic signed [h2r_pkg::Q_W-1:0] p_i,
  input  logic signed [h2r_pkg::D_W-1:0] diff_i,
  input  h2r_pkg::weight_t             w_i,
  output logic [h2r_pkg::CH_W-1:0]     ch_o
);
  import h2r_pkg::*;

  logic signed [PR_W-1:0] prod_d, prod_q;
  logic signed [Q_W-1:0]  p_q;
  logic signed [V_W-1:0]  v_d, v_q;
  logic signed [T_W-1:0]  t17;
  logic signed [T_W-1:0]  sc;
  logic [CH_W-1:0]        ch_d, ch_q;

  always_comb begin
    prod_d = PR_W'(diff_i) * PR_W'(signed'({1'b0, w_i}));
    // 60*p + (q-p)*w
    v_d    = (V_W'(p_q) <<< 6) - (V_W'(p_q) <<< 2) + V_W'(prod_q);
    t17    = (T_W'(v_q) <<< 4) + T_W'(v_q);
    sc     = t17 >>> OUT_SHIFT;
    if (v_q[V_W-1] || (v_q == '0)) begin
      ch_d = '0;
    end else if (|sc[T_W-1:CH_W]) begin
      ch_d = CH_MAX;
    end else begin
      ch_d = sc[CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
      p_q    <= p_i;
    end
    if (en_i[1]) begin
      v_q <= v_d;
    end
    if (en_i[2]) begin
      ch_q <= ch_d;
    end
  end

  assign ch_o = ch_q;

endmodule

// File: hdl/hsl_to_rgb_converter.sv
// Top level of the HSL to RGB pixel converter.
//
// Usage:
//   Input channel in_valid_i/in_ready_o/in_beat_i carries one pixel a beat:
//   hue in whole degrees, saturation and lightness with 1.0 == 4096.
//   Output channel out_valid_o/out_ready_i/out_beat_o carries 8-bit R, G, B.
//   A beat moves on a rising edge with valid and ready both high.
// Throughput: one pixel per cycle; the five-stage pipeline (reduce/multiply,
//   intermediates, ramp multiply, sum, scale/clamp) is limited by nothing
//   but the sink.
// Stall: every stage has its own valid bit and loads when it is empty or
//   when the stage after it moves, so bubbles squeeze out and in_ready_o
//   stays high while any stage is free, even with a result held at the output.
//   A held output beat keeps its payload until taken.
// Reset: rst_ni (async, active low) clears all valid bits; datapath registers
//   are not reset. No configuration, no state between pixels.
module hsl_to_rgb_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  h2r_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output h2r_pkg::out_beat_t out_beat_o
);
  import h2r_pkg::*;

  logic [STAGES-1:0] valid_q;
  logic [STAGES-1:0] en;
  prep_t             prep;
  mix_t              mix;

  // Stage k loads when empty or when its contents move on.
  always_comb begin
    en[STAGES-1] = !valid_q[STAGES-1] || out_ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Stage 1: hue mod 360, ramp weights, l*s.
  h2r_prep u_prep (
    .clk_i  (clk_i),
    .en_i   (en[0]),
    .beat_i (in_beat_i),
    .prep_o (prep)
  );

  // Stage 2: p and q-p.
  h2r_mix u_mix (
    .clk_i  (clk_i),
    .en_i   (en[1]),
    .prep_i (prep),
    .mix_o  (mix)
  );

  // Stages 3-5, one lane per channel.
  h2r_chan u_red (
    .clk_i  (clk_i),
    .en_i   (en[4:2]),
    .p_i    (mix.p),
    .diff_i (mix.diff),
    .w_i    (mix.w.red),
    .ch_o   (out_beat_o.red)
  );

  h2r_chan u_green (
    .clk_i  (clk_i),
    .en_i   (en[4:2]),
    .p_i    (mix.p),
    .diff_i (mix.diff),
    .w_i    (mix.w.green),
    .ch_o   (out_beat_o.green)
  );

  h2r_chan u_blue (
    .clk_i  (clk_i),
    .en_i   (en[4:2]),
    .p_i    (mix.p),
    .diff_i (mix.diff),
    .w_i    (mix.w.blue),
    .ch_o   (out_beat_o.blue)
  );

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[STAGES-1];

endmodule

// File: hdl/h2r_checker.sv
// Port-level checks of the HSL to RGB converter, bound to the top level.
`include "assert_macros.svh"

module h2r_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input h2r_pkg::out_beat_t out_beat_o
);

  `H2R_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "output beat dropped")
  `H2R_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_beat_o), "held beat changed")
  `H2R_ASSERT_IMPL(a_no_backpressure, out_ready_i, in_ready_o, "input stalled with ready sink")
  `H2R_ASSERT_NEXT(a_latency, (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i, out_valid_o, "pixel late through pipeline")

endmodule

bind hsl_to_rgb_converter h2r_checker u_h2r_checker (.*);
